FILE: hdl/pws_pkg.sv
package pws_pkg;

  localparam int VOICES_DEF  = 8;
  localparam int OCTAVES_DEF = 8;
  localparam int SEMIS       = 12;
  localparam int ADDR_W      = 4;
  localparam int DIV_BITS    = 16;
  localparam int VOL_SHIFT   = 6;
  localparam int BEND_SHIFT  = 3;

  localparam logic [2:0] BASE_OCT  = 3'd4;
  localparam logic [7:0] MID       = 8'd128;
  localparam logic [7:0] PULSE_AMP = 8'd127;
  localparam logic [7:0] TOP_MAX   = 8'd255;
  localparam logic [9:0] MIX_OFS   = 10'd128;

  typedef enum logic [1:0] {FN_TICK, FN_PRESS, FN_RELEASE, FN_TABLE} func_t;
  typedef enum logic [1:0] {WAVE_SAW, WAVE_PULSE, WAVE_SINE, WAVE_TRI} wave_t;
  typedef enum logic [1:0] {REG_WAVE, REG_MASTER, REG_VOLUME, REG_NONE} reg_t;
  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_SCALE, ST_FIN} state_t;

  typedef struct packed {
    logic       vld;
    logic       act;
    logic [2:0] oct;
  } vreq_t;

  typedef struct packed {
    logic       vld;
    logic       act;
    logic [7:0] top;
  } tap_t;

endpackage

FILE: hdl/pws_voice_bank.sv
module pws_voice_bank import pws_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  vreq_t                                   req,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] rd_idx,
  input  logic [3:0]                              bend,
  input  logic                                    st_we,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] st_idx,
  input  logic [31:0]                             st_data,
  output tap_t                                    tap,
  output logic                                    busy
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [31:0] phase_mem [VOICES];
  logic [31:0] step_mem  [VOICES];

  logic [VOICES-1:0] ph_ok_r;
  logic [31:0]       ph_q;
  logic [31:0]       st_q;
  logic              ph_ok_q;

  vreq_t             p1_r;
  logic [VW-1:0]     p1_idx_r;

  logic              p2_vld_r;
  logic              p2_act_r;
  logic [VW-1:0]     p2_idx_r;
  logic [31:0]       ph_r;
  logic [31:0]       inc_r;

  logic [31:0]       shifted;
  logic [31:0]       prod;
  logic [31:0]       inc_nxt;
  logic [31:0]       newph;
  logic              ph_we;

  always_comb begin
    if (p1_r.oct < BASE_OCT) begin
      shifted = st_q >> (BASE_OCT - p1_r.oct);
    end else begin
      shifted = st_q << (p1_r.oct - BASE_OCT);
    end
    prod    = 32'(shifted * 32'(bend));
    inc_nxt = prod >> BEND_SHIFT;
  end

  assign newph = ph_r + inc_r;
  assign ph_we = p2_vld_r && p2_act_r;

  always_ff @(posedge clk) begin
    if (req.vld) begin
      ph_q    <= phase_mem[rd_idx];
      st_q    <= step_mem[rd_idx];
      ph_ok_q <= ph_ok_r[rd_idx];
    end
    if (ph_we) begin
      phase_mem[p2_idx_r] <= newph;
    end
    if (st_we) begin
      step_mem[st_idx] <= st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_ok_r  <= '0;
      p1_r     <= '0;
      p2_vld_r <= 1'b0;
      p2_act_r <= 1'b0;
    end else begin
      if (ph_we) begin
        ph_ok_r[p2_idx_r] <= 1'b1;
      end
      p1_r     <= req;
      p2_vld_r <= p1_r.vld;
      p2_act_r <= p1_r.vld && p1_r.act;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= rd_idx;
    p2_idx_r <= p1_idx_r;
    ph_r     <= ph_ok_q ? ph_q : '0;
    inc_r    <= inc_nxt;
  end

  assign tap.vld = p2_vld_r;
  assign tap.act = p2_act_r;
  assign tap.top = newph[31:24];
  assign busy    = p1_r.vld || p2_vld_r;

endmodule

FILE: hdl/pws_wave.sv
module pws_wave import pws_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  wave_t             wave,
  input  tap_t              tap,
  input  logic              tb_we,
  input  logic [7:0]        tb_idx,
  input  logic signed [7:0] tb_val,
  output logic signed [9:0] mix,
  output logic              busy
);

  localparam int         RECIP   = ((1 << DIV_BITS) + VOICES - 1) / VOICES;
  localparam logic [16:0] RECIP_W = 17'(RECIP);

  logic [7:0] sine_mem [256];
  logic [7:0] sine_q;

  logic       t3_vld_r;
  logic       t3_act_r;
  logic [7:0] t3_top_r;

  logic       t4_vld_r;
  logic       t4_act_r;
  logic [7:0] mag_r;
  logic       neg_r;

  logic       neg_nxt;
  logic [7:0] mag_nxt;
  logic [24:0] qprod;
  logic [7:0]  quot;
  logic signed [9:0] mix_r;

  always_ff @(posedge clk) begin
    if (tb_we) begin
      sine_mem[tb_idx] <= tb_val;
    end
    sine_q <= sine_mem[tap.top];
  end

  always_comb begin
    neg_nxt = 1'b0;
    mag_nxt = '0;
    case (wave)
      WAVE_SAW: begin
        neg_nxt = ~t3_top_r[7];
        mag_nxt = t3_top_r[7] ? {1'b0, t3_top_r[6:0]} : 8'(MID - t3_top_r);
      end
      WAVE_PULSE: begin
        neg_nxt = ~t3_top_r[7];
        mag_nxt = PULSE_AMP;
      end
      WAVE_SINE: begin
        neg_nxt = sine_q[7];
        mag_nxt = sine_q[7] ? 8'(~sine_q + 8'd1) : sine_q;
      end
      WAVE_TRI: begin
        neg_nxt = 1'b0;
        mag_nxt = t3_top_r[7] ? 8'(TOP_MAX - t3_top_r) : t3_top_r;
      end
      default: begin
        neg_nxt = 1'b0;
        mag_nxt = '0;
      end
    endcase
  end

  assign qprod = 25'(mag_r) * 25'(RECIP_W);
  assign quot  = qprod[DIV_BITS+7:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_vld_r <= 1'b0;
      t3_act_r <= 1'b0;
      t4_vld_r <= 1'b0;
      t4_act_r <= 1'b0;
      mix_r    <= '0;
    end else begin
      t3_vld_r <= tap.vld;
      t3_act_r <= tap.act;
      t4_vld_r <= t3_vld_r;
      t4_act_r <= t3_vld_r && t3_act_r;
      if (clr) begin
        mix_r <= '0;
      end else if (t4_vld_r && t4_act_r) begin
        mix_r <= neg_r ? mix_r - signed'({2'b00, quot}) : mix_r + signed'({2'b00, quot});
      end
    end
  end

  always_ff @(posedge clk) begin
    t3_top_r <= tap.top;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
  end

  assign mix  = mix_r;
  assign busy = t3_vld_r || t4_vld_r;

endmodule

FILE: hdl/polyphonic_wave_synth_top.sv
// Tick: with master enabled, the run, drain and scale states follow and the result is loaded into the output register.
// Press, release and sine table write: accepted back to back while idle.
// A tick holds the input off until its result is loaded: the voice walk reads one voice
// a cycle from the phase/step memories, then drains a four-stage pipeline.
// Reset (synchronous): all voices free, phases read as zero, registers to defaults;
// the sine table is not cleared.
module polyphonic_wave_synth_top import pws_pkg::*; #(
  parameter int VOICES  = VOICES_DEF,
  parameter int OCTAVES = OCTAVES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [3:0]        in_semitone,
  input  logic [2:0]        in_octave,
  input  logic [31:0]       in_step_size,
  input  logic [7:0]        in_table_index,
  input  logic signed [7:0] in_table_value,
  input  logic [3:0]        in_pitch_bend,
  input  logic [3:0]        in_volume_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_sample
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  wave_t             wave_r;
  logic              master_r;
  logic [4:0]        vol_base_r;
  logic              cfg_we;

  state_t            state_r;
  state_t            state_nxt;
  logic [VW-1:0]     cnt_r;
  logic [VW-1:0]     cnt_nxt;
  logic              last;

  logic [VOICES-1:0] busy_r;
  logic [VOICES-1:0] busy_nxt;
  logic [2:0]        oct_r  [VOICES];
  logic [3:0]        semi_r [VOICES];

  logic [VOICES-1:0] match;
  logic              held;
  logic              any_free;
  logic [VW-1:0]     free_idx;
  logic              key_ok;
  logic              in_acc;
  func_t             func;
  logic              press_do;
  logic              rel_do;
  logic              tick_go;
  logic              tb_we;

  logic [3:0]        bend_r;
  logic [3:0]        voff_r;
  vreq_t             req;
  tap_t              tap;
  logic              vb_busy;
  logic              wv_busy;
  logic              pipe_busy;
  logic signed [9:0] mix;
  logic              mix_clr;

  logic [9:0]        sum10;
  logic [5:0]        vol;
  logic [14:0]       scale_r;
  logic [8:0]        s9;
  logic              out_load;
  logic              out_valid_r;
  logic [7:0]        out_sample_r;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r     <= WAVE_SAW;
      master_r   <= 1'b1;
      vol_base_r <= 5'd8;
    end else if (cfg_we) begin
      case (reg_t'(paddr[3:2]))
        REG_WAVE:   wave_r     <= wave_t'(pwdata[1:0]);
        REG_MASTER: master_r   <= pwdata[0];
        REG_VOLUME: vol_base_r <= pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_t'(paddr[3:2]))
      REG_WAVE:   prdata = {30'd0, wave_r};
      REG_MASTER: prdata = {31'd0, master_r};
      REG_VOLUME: prdata = {27'd0, vol_base_r};
      default:    prdata = '0;
    endcase
  end

  // voice allocation
  assign func   = func_t'(in_func);
  assign in_acc = in_valid && in_ready;
  assign key_ok = (in_semitone < 4'(SEMIS)) && ({1'b0, in_octave} < 4'(OCTAVES));

  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      match[v] = busy_r[v] && (oct_r[v] == in_octave) && (semi_r[v] == in_semitone);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!busy_r[v]) begin
        free_idx = VW'(v);
      end
    end
  end

  assign held     = |match;
  assign any_free = ~&busy_r;
  assign press_do = in_acc && (func == FN_PRESS) && key_ok && !held && any_free;
  assign rel_do   = in_acc && (func == FN_RELEASE) && key_ok && held;
  assign tick_go  = in_acc && (func == FN_TICK) && master_r;
  assign tb_we    = in_acc && (func == FN_TABLE);

  always_comb begin
    busy_nxt = busy_r;
    if (press_do) begin
      busy_nxt[free_idx] = 1'b1;
    end
    if (rel_do) begin
      busy_nxt = busy_r & ~match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (press_do) begin
      oct_r[free_idx]  <= in_octave;
      semi_r[free_idx] <= in_semitone;
    end
  end

  // sequencer
  assign last      = (cnt_r == VW'(VOICES - 1));
  assign pipe_busy = vb_busy || wv_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (tick_go) state_nxt = ST_RUN;
      ST_RUN:   if (last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_FIN;
      ST_FIN:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    req.vld  = (state_r == ST_RUN);
    req.act  = busy_r[cnt_r];
    req.oct  = oct_r[cnt_r];
    mix_clr  = tick_go;
    out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (tick_go) begin
      cnt_nxt = '0;
    end else if (state_r == ST_RUN) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      bend_r <= in_pitch_bend;
      voff_r <= in_volume_offset;
    end
  end

  pws_voice_bank #(
    .VOICES (VOICES)
  ) u_voice_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_idx  (cnt_r),
    .bend    (bend_r),
    .st_we   (press_do),
    .st_idx  (free_idx),
    .st_data (in_step_size),
    .tap     (tap),
    .busy    (vb_busy)
  );

  pws_wave #(
    .VOICES (VOICES)
  ) u_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mix_clr),
    .wave   (wave_r),
    .tap    (tap),
    .tb_we  (tb_we),
    .tb_idx (in_table_index),
    .tb_val (in_table_value),
    .mix    (mix),
    .busy   (wv_busy)
  );

  // scale and clamp; mix never drops below -128
  assign sum10 = unsigned'(mix) + MIX_OFS;
  assign vol   = {1'b0, vol_base_r} + {2'b00, voff_r};
  assign s9    = scale_r[14:VOL_SHIFT];

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      scale_r <= 15'(sum10[8:0] * vol);
    end
    if (out_load) begin
      out_sample_r <= s9[8] ? TOP_MAX : s9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

`ifndef SYNTHESIS
  a_press_takes_voice: assert property (@(posedge clk) disable iff (!rst_n)
    press_do |=> $countones(busy_r) == $past($countones(busy_r)) + 1)
    else $error("press did not take exactly one voice");

  a_release_frees_voice: assert property (@(posedge clk) disable iff (!rst_n)
    rel_do |=> $countones(busy_r) + 1 == $past($countones(busy_r)))
    else $error("release did not free exactly one voice");

  a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCALE) |-> !pipe_busy)
    else $error("scaling started with voices still in flight");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");
`endif

endmodule
